// ===== design/ip_address_text_checker_defines.svh =====
// assertion macros for the ip address text checker
`ifndef IP_ADDRESS_TEXT_CHECKER_DEFINES_SVH
`define IP_ADDRESS_TEXT_CHECKER_DEFINES_SVH

// condition now implies a consequence in the same cycle
`define IPCHK_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// condition now implies a consequence in the next cycle
`define IPCHK_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== design/ipchk_pkg.sv =====
// package with constants, types and character classes for the address checker
package ipchk_pkg;

	localparam int unsigned CHAR_W = 8;

	localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;

	localparam logic [5:0] LEN_SAT     = 6'd63;
	localparam logic [5:0] V4_MAX_LEN  = 6'd15;
	localparam logic [5:0] V6_MAX_LEN  = 6'd39;

	localparam logic [2:0] V4_DOTS      = 3'd3;
	localparam logic [2:0] DOT_SAT      = 3'd4;
	localparam logic [2:0] V4_GROUP_MAX = 3'd3;
	localparam logic [2:0] DEC_SAT      = 3'd4;

	localparam logic [2:0] V6_GROUP_MAX = 3'd4;
	localparam logic [2:0] HEX_SAT      = 3'd5;
	localparam logic [3:0] SINGLE_SAT   = 4'd15;
	localparam logic [1:0] DOUBLE_SAT   = 2'd3;
	localparam logic [3:0] V6_SINGLES_WITH_MARK = 4'd5;
	localparam logic [3:0] V6_SINGLES_NO_MARK   = 4'd7;

	typedef struct packed {
		logic               take;
		logic               is_last;
		logic [CHAR_W-1:0]  char_code;
	} step_t;

	typedef struct packed {
		logic ipv4_ok;
		logic ipv6_ok;
	} verdict_t;

	function automatic logic is_dec(input logic [CHAR_W-1:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_hex(input logic [CHAR_W-1:0] c);
		return is_dec(c) || ((c >= 8'h41) && (c <= 8'h46)) ||
			((c >= 8'h61) && (c <= 8'h66));
	endfunction

endpackage

// ===== design/ipchk_char_if.sv =====
// character stream channel
interface ipchk_char_if;
	logic                           valid;
	logic                           ready;
	logic [ipchk_pkg::CHAR_W-1:0]   char_code;
	logic                           is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// ===== design/ipchk_verdict_if.sv =====
// verdict result channel
interface ipchk_verdict_if;
	logic valid;
	logic ready;
	logic ipv4_ok;
	logic ipv6_ok;

	modport source (output valid, output ipv4_ok, output ipv6_ok, input ready);
	modport sink   (input valid, input ipv4_ok, input ipv6_ok, output ready);
endinterface

// ===== design/ipchk_scan.sv =====
// running counters and verdict logic for one address text
module ipchk_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  ipchk_pkg::step_t    step,
	output ipchk_pkg::verdict_t verdict
);

	logic [5:0] len_q;
	logic [2:0] dots_q;
	logic [2:0] dec_len_q;
	logic       v4_good_q;
	logic [3:0] single_q;
	logic [1:0] double_q;
	logic [2:0] hex_len_q;
	logic       pend_q;
	logic       v6_good_q;

	logic [5:0] len_n;
	logic [2:0] dots_n;
	logic [2:0] dec_len_n;
	logic       v4_good_n;
	logic [3:0] single_n;
	logic [1:0] double_n;
	logic [2:0] hex_len_n;
	logic       pend_n;
	logic       v6_good_n;
	logic       v4_ok;
	logic       v6_ok;

	always_comb begin
		len_n     = (len_q < ipchk_pkg::LEN_SAT) ? len_q + 6'd1 : len_q;
		dots_n    = dots_q;
		dec_len_n = dec_len_q;
		v4_good_n = v4_good_q;
		single_n  = single_q;
		double_n  = double_q;
		hex_len_n = hex_len_q;
		pend_n    = pend_q;
		v6_good_n = v6_good_q;

		// dotted decimal
		if (ipchk_pkg::is_dec(step.char_code)) begin
			dec_len_n = (dec_len_q < ipchk_pkg::DEC_SAT) ? dec_len_q + 3'd1 : dec_len_q;
			if (dec_len_n > ipchk_pkg::V4_GROUP_MAX) v4_good_n = 1'b0;
		end else if (step.char_code == ipchk_pkg::CHAR_DOT) begin
			if (dec_len_q == 3'd0) v4_good_n = 1'b0;
			dots_n = (dots_q < ipchk_pkg::DOT_SAT) ? dots_q + 3'd1 : dots_q;
			if (dots_n > ipchk_pkg::V4_DOTS) v4_good_n = 1'b0;
			dec_len_n = 3'd0;
		end else begin
			v4_good_n = 1'b0;
		end

		// colon hex, colons pair from the left
		if (step.char_code == ipchk_pkg::CHAR_COLON) begin
			if (pend_q) begin
				double_n = (double_q < ipchk_pkg::DOUBLE_SAT) ? double_q + 2'd1 : double_q;
				pend_n   = 1'b0;
			end else begin
				pend_n = 1'b1;
			end
			hex_len_n = 3'd0;
		end else begin
			if (pend_q) begin
				single_n = (single_q < ipchk_pkg::SINGLE_SAT) ? single_q + 4'd1 : single_q;
				pend_n   = 1'b0;
			end
			if (ipchk_pkg::is_hex(step.char_code)) begin
				hex_len_n = (hex_len_q < ipchk_pkg::HEX_SAT) ? hex_len_q + 3'd1 : hex_len_q;
				if (hex_len_n > ipchk_pkg::V6_GROUP_MAX) v6_good_n = 1'b0;
			end else begin
				v6_good_n = 1'b0;
			end
		end

		v4_ok = v4_good_n && (len_n <= ipchk_pkg::V4_MAX_LEN) &&
			(dots_n == ipchk_pkg::V4_DOTS) && (dec_len_n != 3'd0);

		v6_ok = v6_good_n && (len_n <= ipchk_pkg::V6_MAX_LEN) && !pend_n &&
			(double_n <= 2'd1);
		if ((double_n == 2'd1) && (single_n > ipchk_pkg::V6_SINGLES_WITH_MARK)) v6_ok = 1'b0;
		if ((double_n == 2'd0) && (single_n > ipchk_pkg::V6_SINGLES_NO_MARK)) v6_ok = 1'b0;

		verdict.ipv4_ok = v4_ok;
		verdict.ipv6_ok = v6_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			dots_q    <= '0;
			dec_len_q <= '0;
			v4_good_q <= 1'b1;
			single_q  <= '0;
			double_q  <= '0;
			hex_len_q <= '0;
			pend_q    <= 1'b0;
			v6_good_q <= 1'b1;
		end else if (step.take) begin
			if (step.is_last) begin
				len_q     <= '0;
				dots_q    <= '0;
				dec_len_q <= '0;
				v4_good_q <= 1'b1;
				single_q  <= '0;
				double_q  <= '0;
				hex_len_q <= '0;
				pend_q    <= 1'b0;
				v6_good_q <= 1'b1;
			end else begin
				len_q     <= len_n;
				dots_q    <= dots_n;
				dec_len_q <= dec_len_n;
				v4_good_q <= v4_good_n;
				single_q  <= single_n;
				double_q  <= double_n;
				hex_len_q <= hex_len_n;
				pend_q    <= pend_n;
				v6_good_q <= v6_good_n;
			end
		end
	end

endmodule

// ===== design/ip_address_text_checker.sv =====
// top level of the ipv4 / ipv6 address text checker
// usage:
//   chars carries the address text, one ascii byte per transaction, with
//   is_last set on the final byte of each address. verdicts carries one
//   transaction per address with the ipv4_ok and ipv6_ok syntax verdicts.
//   bytes without is_last produce no verdict.
// path: a byte is first registered in the input stage, where the counters
//   update as it moves on; the verdict of a last byte is then registered in
//   the verdict register and is shown on verdicts from there.
// throughput: one byte per cycle, unless a final byte waits in the input
//   stage for the verdict register to free (see stall).
// stall: while a verdict waits on verdicts, non-final bytes keep flowing;
//   a final byte waits in the input stage until the verdict register frees,
//   and chars.ready drops only then.
// reset: arst_n clears the counters to an empty address and drops both
//   valid flags; the next byte starts a new address.
`include "ip_address_text_checker_defines.svh"

module ip_address_text_checker (
	input  logic              clk,
	input  logic              arst_n,
	ipchk_char_if.sink        chars,
	ipchk_verdict_if.source   verdicts
);

	logic                          valid_s1;
	logic                          last_s1;
	logic [ipchk_pkg::CHAR_W-1:0]  char_s1;
	logic                          out_valid_q;
	ipchk_pkg::verdict_t           verdict_q;
	ipchk_pkg::verdict_t           verdict;
	ipchk_pkg::step_t              step;
	logic                          advance;

	// a final byte needs a free verdict register to move on
	assign advance = !last_s1 || !out_valid_q || verdicts.ready;
	assign chars.ready = !valid_s1 || advance;

	assign step.take      = valid_s1 && advance;
	assign step.is_last   = last_s1;
	assign step.char_code = char_s1;

	ipchk_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.verdict (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step.take && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdicts.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.take && last_s1) begin
			verdict_q <= verdict;
		end
	end

	assign verdicts.valid   = out_valid_q;
	assign verdicts.ipv4_ok = verdict_q.ipv4_ok;
	assign verdicts.ipv6_ok = verdict_q.ipv6_ok;

	`IPCHK_ASSERT_NEXT(a_last_gives_verdict, step.take && last_s1, out_valid_q, "final byte gave no verdict")
	`IPCHK_ASSERT_NEXT(a_no_spurious_verdict, step.take && !last_s1 && !out_valid_q, !out_valid_q, "verdict without final byte")
	`IPCHK_ASSERT_NOW(a_formats_exclusive, out_valid_q, !(verdict_q.ipv4_ok && verdict_q.ipv6_ok), "both formats accepted")

endmodule
